>>> rtl/core/msfl_pkg.sv
// package for the multi-stack free-list block: defaults, codes, beat types
// no dependencies
package msfl_pkg;

    // default sizing
    localparam int CAPACITY_DEF   = 64;
    localparam int NUM_STACKS_DEF = 8;

    // fixed field widths
    localparam int DATA_W = 32;
    localparam int ID_W   = 3;

    // request kinds
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // request beat
    typedef struct packed {
        logic                     req_type;
        logic [ID_W-1:0]          stack_id;
        logic signed [DATA_W-1:0] push_value;
    } req_t;

    // result beat
    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        status_t                  status;
    } rsp_t;

    // memory port controls from controller to store
    typedef struct packed {
        logic rd_en;
        logic wr_value_en;
        logic wr_link_en;
    } mem_ctl_t;

endpackage

>>> rtl/core/msfl_store.sv
// slot store: value memory and link memory, one read and one write port each
// depends on msfl_pkg
module msfl_store #(
    parameter int CAPACITY = msfl_pkg::CAPACITY_DEF,
    localparam int ADDR_W  = $clog2(CAPACITY),
    localparam int LINK_W  = $clog2(CAPACITY + 1)
) (
    input  logic                             clk,
    input  msfl_pkg::mem_ctl_t               ctl,
    input  logic [ADDR_W-1:0]                rd_addr,
    input  logic [ADDR_W-1:0]                wr_addr,
    input  logic signed [msfl_pkg::DATA_W-1:0] wr_value,
    input  logic [LINK_W-1:0]                wr_link,
    output logic signed [msfl_pkg::DATA_W-1:0] rd_value,
    output logic [LINK_W-1:0]                rd_link
);

    logic signed [msfl_pkg::DATA_W-1:0] value_mem [CAPACITY];
    logic [LINK_W-1:0]                  link_mem  [CAPACITY];
    logic signed [msfl_pkg::DATA_W-1:0] rd_value_reg;
    logic [LINK_W-1:0]                  rd_link_reg;

    // write ports
    always_ff @(posedge clk)
    begin
        if (ctl.wr_value_en)
        begin
            value_mem[wr_addr] <= wr_value;
        end
        if (ctl.wr_link_en)
        begin
            link_mem[wr_addr] <= wr_link;
        end
    end

    // registered read ports
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_value_reg <= value_mem[rd_addr];
            rd_link_reg  <= link_mem[rd_addr];
        end
    end

    assign rd_value = rd_value_reg;
    assign rd_link  = rd_link_reg;

endmodule

>>> rtl/core/msfl_ctrl.sv
// controller: stack tops, free-list head, fill mark and the idle/execute sequencer
// depends on msfl_pkg; drives the ports of msfl_store
module msfl_ctrl #(
    parameter int CAPACITY   = msfl_pkg::CAPACITY_DEF,
    parameter int NUM_STACKS = msfl_pkg::NUM_STACKS_DEF,
    localparam int ADDR_W    = $clog2(CAPACITY),
    localparam int LINK_W    = $clog2(CAPACITY + 1),
    localparam int SID_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  msfl_pkg::req_t                     req,
    output logic                               busy,
    output logic                               done,
    output msfl_pkg::rsp_t                     result,
    output msfl_pkg::mem_ctl_t                 mem_ctl,
    output logic [ADDR_W-1:0]                  rd_addr,
    output logic [ADDR_W-1:0]                  wr_addr,
    output logic signed [msfl_pkg::DATA_W-1:0] wr_value,
    output logic [LINK_W-1:0]                  wr_link,
    input  logic signed [msfl_pkg::DATA_W-1:0] rd_value,
    input  logic [LINK_W-1:0]                  rd_link
);

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(CAPACITY);
    localparam logic [LINK_W-1:0] LAST_SLOT = LINK_W'(CAPACITY - 1);

    msfl_pkg::state_t  state_reg, state_next;
    msfl_pkg::req_t    req_reg;
    logic              id_ok_reg;
    logic [LINK_W-1:0] slot_reg;
    logic [LINK_W-1:0] free_head_reg;
    logic [LINK_W-1:0] fresh_reg;
    logic [LINK_W-1:0] tops_reg [NUM_STACKS];
    msfl_pkg::rsp_t    result_reg;
    logic              done_reg;

    logic              accept;
    logic              id_ok;
    logic [SID_W-1:0]  sid_idx;
    logic [SID_W-1:0]  sid_idx_q;
    logic [LINK_W-1:0] slot_sel;
    logic [LINK_W-1:0] link_eff;
    logic [LINK_W-1:0] old_top;
    logic              op_ok;
    logic              is_push;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msfl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and handshake
    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        case (state_reg)
            msfl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = msfl_pkg::S_EXEC;
                end
            end
            msfl_pkg::S_EXEC:
            begin
                busy       = 1'b1;
                state_next = msfl_pkg::S_IDLE;
            end
            default:
            begin
                state_next = msfl_pkg::S_IDLE;
            end
        endcase
    end

    assign accept = start && !busy;

    // slot lookup at accept: free head for push, stack top for pop, null for a pop to a bad stack
    assign id_ok   = 32'(req.stack_id) < NUM_STACKS;
    assign sid_idx = SID_W'(req.stack_id);
    always_comb
    begin
        if (req.req_type == msfl_pkg::REQ_PUSH)
        begin
            slot_sel = free_head_reg;
        end
        else if (id_ok)
        begin
            slot_sel = tops_reg[sid_idx];
        end
        else
        begin
            slot_sel = LINK_NULL;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req;
            id_ok_reg <= id_ok;
            slot_reg  <= slot_sel;
        end
    end

    // execute-cycle decode
    assign sid_idx_q = SID_W'(req_reg.stack_id);
    assign is_push   = req_reg.req_type == msfl_pkg::REQ_PUSH;
    assign op_ok     = (state_reg == msfl_pkg::S_EXEC) && id_ok_reg && (slot_reg != LINK_NULL);
    assign old_top   = tops_reg[sid_idx_q];

    // slots at or above the fill mark were never written: link is the next slot, or null for the last slot
    always_comb
    begin
        if (slot_reg >= fresh_reg)
        begin
            link_eff = (slot_reg == LAST_SLOT) ? LINK_NULL : slot_reg + LINK_W'(1);
        end
        else
        begin
            link_eff = rd_link;
        end
    end

    // memory port drive
    assign mem_ctl.rd_en       = accept;
    assign mem_ctl.wr_value_en = op_ok && is_push;
    assign mem_ctl.wr_link_en  = op_ok;
    assign rd_addr  = ADDR_W'(slot_sel);
    assign wr_addr  = ADDR_W'(slot_reg);
    assign wr_value = req_reg.push_value;
    assign wr_link  = is_push ? old_top : free_head_reg;

    // list heads and fill mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            fresh_reg     <= '0;
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                tops_reg[i] <= LINK_NULL;
            end
        end
        else if (op_ok)
        begin
            if (is_push)
            begin
                free_head_reg       <= link_eff;
                tops_reg[sid_idx_q] <= slot_reg;
                if (slot_reg == fresh_reg)
                begin
                    fresh_reg <= fresh_reg + LINK_W'(1);
                end
            end
            else
            begin
                free_head_reg       <= slot_reg;
                tops_reg[sid_idx_q] <= link_eff;
            end
        end
    end

    // result beat register
    always_ff @(posedge clk)
    begin
        if (state_reg == msfl_pkg::S_EXEC)
        begin
            result_reg.pop_value <= (op_ok && !is_push) ? rd_value : '0;
            if (op_ok)
            begin
                result_reg.status <= msfl_pkg::ST_OK;
            end
            else if (is_push)
            begin
                result_reg.status <= msfl_pkg::ST_OVERFLOW;
            end
            else
            begin
                result_reg.status <= msfl_pkg::ST_UNDERFLOW;
            end
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == msfl_pkg::S_EXEC);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/core/multi_stack_free_list_top.sv
// top level of the multi-stack free-list block
// depends on msfl_pkg, msfl_store, msfl_ctrl
//
// NUM_STACKS LIFO stacks share one store of CAPACITY slots; unused slots sit on
// a free list. A request is taken when start is high and busy is low. The
// accept edge loads the slot's value and link from the store memories, and the
// following busy cycle writes the link back and updates the stack top and free
// head. No new request is taken while busy, so one request finishes before the
// next is taken. Exactly one result beat follows each request, with done,
// registered from the execute state, high for one cycle; the receiver cannot
// stall, so it must take the beat in that cycle. Stack numbers not below
// NUM_STACKS answer overflow on push and underflow on pop. The link store needs
// no clearing pass after reset: a fill mark stands in for the initial free-list
// chain, so the block is ready right out of reset.
module multi_stack_free_list_top #(
    parameter int CAPACITY   = msfl_pkg::CAPACITY_DEF,
    parameter int NUM_STACKS = msfl_pkg::NUM_STACKS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  msfl_pkg::req_t req,
    output logic           busy,
    output logic           done,
    output msfl_pkg::rsp_t result
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int LINK_W = $clog2(CAPACITY + 1);

    msfl_pkg::mem_ctl_t                 mem_ctl;
    logic [ADDR_W-1:0]                  rd_addr;
    logic [ADDR_W-1:0]                  wr_addr;
    logic signed [msfl_pkg::DATA_W-1:0] wr_value;
    logic [LINK_W-1:0]                  wr_link;
    logic signed [msfl_pkg::DATA_W-1:0] rd_value;
    logic [LINK_W-1:0]                  rd_link;

    // sequencer and list heads
    msfl_ctrl #(
        .CAPACITY   (CAPACITY),
        .NUM_STACKS (NUM_STACKS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .mem_ctl  (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_value (wr_value),
        .wr_link  (wr_link),
        .rd_value (rd_value),
        .rd_link  (rd_link)
    );

    // value and link memories
    msfl_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk      (clk),
        .ctl      (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_value (wr_value),
        .wr_link  (wr_link),
        .rd_value (rd_value),
        .rd_link  (rd_link)
    );

endmodule

>>> rtl/core/msfl_checker.sv
// port-level checker for the multi-stack free-list block, with its bind
// depends on msfl_pkg and multi_stack_free_list_top
module msfl_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input msfl_pkg::req_t req,
    input logic           busy,
    input logic           done,
    input msfl_pkg::rsp_t result
);

    // every accepted beat gets its result beat
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("no result beat after accepted request");

    // no result beat without an earlier accepted request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result beat without a request");

    // block is busy in the cycle after an accept
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after accept");

    // failed requests and pushes return a zero value
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != msfl_pkg::ST_OK ||
                  $past(req.req_type, 2) == msfl_pkg::REQ_PUSH))
        |-> result.pop_value == 0)
        else $error("nonzero value on push or failed request");

endmodule

bind multi_stack_free_list_top msfl_checker u_checker (.*);
